FILE: src/demb_pkg.sv
// ----------------------------------------------------------------------------
// demb_pkg
// Shared types and constants for the diagonal emboss filter.
// ----------------------------------------------------------------------------
package demb_pkg;

	localparam int MAX_WIDTH  = 2048;
	localparam int COL_W      = $clog2(MAX_WIDTH);
	localparam int EW_W       = $clog2(MAX_WIDTH + 1);
	localparam int ROW_W      = 16;
	localparam int CFG_W_W    = 12;
	localparam int OUT_COL_W  = 11;
	localparam int PIX_W      = 24;
	localparam int LB_AW      = COL_W + 1;
	localparam int LB_DEPTH   = 2 ** LB_AW;
	localparam int FIFO_DEPTH = 4;
	localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
	localparam int FIFO_CW    = $clog2(FIFO_DEPTH + 1);
	localparam int PADDR_W    = 4;
	localparam int PDATA_W    = 32;

	localparam logic [7:0] EMB_MID = 8'd128;
	localparam logic [7:0] EMB_MAX = 8'd255;

	localparam logic [CFG_W_W-1:0] RST_WIDTH  = 12'd640;
	localparam logic [ROW_W-1:0]   RST_HEIGHT = 16'd480;

	typedef enum logic [1:0] {
		REG_WIDTH  = 2'd0,
		REG_HEIGHT = 2'd1,
		REG_THREE  = 2'd2,
		REG_NONE   = 2'd3
	} reg_idx_t;

	typedef struct packed {
		logic [7:0] pixel_c0;
		logic [7:0] pixel_c1;
		logic [7:0] pixel_c2;
	} pixel_in_t;

	typedef struct packed {
		logic [15:0]          out_row;
		logic [OUT_COL_W-1:0] out_col;
		logic [7:0]           out_c0;
		logic [7:0]           out_c1;
		logic [7:0]           out_c2;
		logic                 last_of_run;
		logic                 frame_end;
	} result_t;

	typedef struct packed {
		logic [EW_W-1:0]  width;
		logic [ROW_W-1:0] height;
		logic             three;
		logic             restart;
	} cfg_t;

	typedef struct packed {
		logic [1:0] count;
		result_t    first;
		result_t    second;
	} fifo_push_t;

	function automatic logic [7:0] emboss(input logic [7:0] cur, input logic [7:0] old);
		logic signed [9:0] v;
		begin
			v = $signed({2'b00, cur}) - $signed({2'b00, old}) + $signed({2'b00, EMB_MID});
			if (v < 10'sd0) begin
				emboss = 8'd0;
			end else if (v > $signed({2'b00, EMB_MAX})) begin
				emboss = EMB_MAX;
			end else begin
				emboss = v[7:0];
			end
		end
	endfunction

endpackage

FILE: src/demb_cfg.sv
// ----------------------------------------------------------------------------
// demb_cfg
// APB register file: frame width, frame height and channel mode.
// ----------------------------------------------------------------------------
module demb_cfg (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            psel,
	input  logic                            penable,
	input  logic                            pwrite,
	input  logic [demb_pkg::PADDR_W-1:0]    paddr,
	input  logic [demb_pkg::PDATA_W-1:0]    pwdata,
	output logic [demb_pkg::PDATA_W-1:0]    prdata,
	output demb_pkg::cfg_t                  cfg
);
	import demb_pkg::*;

	logic [CFG_W_W-1:0] width_q;
	logic [ROW_W-1:0]   height_q;
	logic               three_q;
	logic               wr_en;
	reg_idx_t           idx;

	assign idx   = reg_idx_t'(paddr[3:2]);
	assign wr_en = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= RST_WIDTH;
			height_q <= RST_HEIGHT;
			three_q  <= 1'b1;
		end else if (wr_en) begin
			case (idx)
				REG_WIDTH:  width_q  <= pwdata[CFG_W_W-1:0];
				REG_HEIGHT: height_q <= pwdata[ROW_W-1:0];
				REG_THREE:  three_q  <= pwdata[0];
				default:    ;
			endcase
		end
	end

	always_comb begin
		case (idx)
			REG_WIDTH:  prdata = PDATA_W'(width_q);
			REG_HEIGHT: prdata = PDATA_W'(height_q);
			REG_THREE:  prdata = PDATA_W'(three_q);
			default:    prdata = '0;
		endcase
	end

	always_comb begin
		if (width_q == '0) begin
			cfg.width = EW_W'(1);
		end else if (32'(width_q) > 32'(MAX_WIDTH)) begin
			cfg.width = EW_W'(MAX_WIDTH);
		end else begin
			cfg.width = EW_W'(width_q);
		end
		cfg.height  = (height_q == '0) ? ROW_W'(1) : height_q;
		cfg.three   = three_q;
		cfg.restart = wr_en && (idx != REG_NONE);
	end

endmodule

FILE: src/demb_line_buf.sv
// ----------------------------------------------------------------------------
// demb_line_buf
// Two-row pixel store with a two-request delay, giving the pixel two rows
// up and two columns left of the current request.
// ----------------------------------------------------------------------------
module demb_line_buf (
	input  logic                          clk,
	input  logic                          en,
	input  logic [demb_pkg::LB_AW-1:0]    addr,
	input  logic [demb_pkg::PIX_W-1:0]    wdata,
	output logic [demb_pkg::PIX_W-1:0]    old
);
	import demb_pkg::*;

	logic [PIX_W-1:0] mem [LB_DEPTH];
	logic [PIX_W-1:0] rd_q;
	logic [PIX_W-1:0] d1_q;
	logic [PIX_W-1:0] d2_q;

	always_ff @(posedge clk) begin
		if (en) begin
			rd_q      <= mem[addr];
			mem[addr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			d1_q <= rd_q;
			d2_q <= d1_q;
		end
	end

	assign old = d2_q;

endmodule

FILE: src/demb_fifo.sv
// ----------------------------------------------------------------------------
// demb_fifo
// Small result queue taking up to two results a cycle, one out a cycle while pop is high and the queue is not empty.
// ----------------------------------------------------------------------------
module demb_fifo (
	input  logic                            clk,
	input  logic                            arst_n,
	input  demb_pkg::fifo_push_t            push,
	input  logic                            pop,
	output logic                            valid,
	output demb_pkg::result_t               head,
	output logic [demb_pkg::FIFO_CW-1:0]    level
);
	import demb_pkg::*;

	result_t              buf_q [FIFO_DEPTH];
	logic [FIFO_AW-1:0]   wr_ptr_q;
	logic [FIFO_AW-1:0]   rd_ptr_q;
	logic [FIFO_CW-1:0]   count_q;
	logic                 do_pop;

	assign do_pop = pop && (count_q != '0);

	always_ff @(posedge clk) begin
		if (push.count != 2'd0) begin
			buf_q[wr_ptr_q] <= push.first;
		end
		if (push.count == 2'd2) begin
			buf_q[wr_ptr_q + FIFO_AW'(1)] <= push.second;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + FIFO_AW'(push.count);
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + FIFO_AW'(1);
			end
			count_q <= count_q + FIFO_CW'(push.count) - FIFO_CW'(do_pop);
		end
	end

	assign valid = (count_q != '0);
	assign head  = buf_q[rd_ptr_q];
	assign level = count_q;

endmodule

FILE: src/diagonal_emboss_filter.sv
// ----------------------------------------------------------------------------
// diagonal_emboss_filter
// Diagonal-difference emboss over a raster pixel stream, borders passed through.
// ----------------------------------------------------------------------------
// throughput: one pixel per cycle while the queue holds two results or fewer; pixels of
//   the last row or column, from row 2 and column 2 on, give two results; the output moves
//   at most one a cycle, so they stall input
// reset: position counters at zero, width 640, height 480, three channels;
//   the row store is not cleared; reads used for results hit pixels written this frame
module diagonal_emboss_filter (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_stall,
	input  demb_pkg::pixel_in_t             in_data,
	output logic                            out_valid,
	input  logic                            out_stall,
	output demb_pkg::result_t               out_data,
	input  logic                            psel,
	input  logic                            penable,
	input  logic                            pwrite,
	input  logic [demb_pkg::PADDR_W-1:0]    paddr,
	input  logic [demb_pkg::PDATA_W-1:0]    pwdata,
	output logic [demb_pkg::PDATA_W-1:0]    prdata,
	output logic                            pready
);
	import demb_pkg::*;

	cfg_t               cfg;
	logic               accept;
	logic               s1_move;
	logic [ROW_W-1:0]   row_q;
	logic [COL_W-1:0]   col_q;
	logic               col_last;
	logic               row_last;
	logic [PIX_W-1:0]   cur;
	logic [PIX_W-1:0]   old;
	logic [FIFO_CW-1:0] level;

	logic               valid_s1;
	logic [PIX_W-1:0]   cur_s1;
	logic [ROW_W-1:0]   row_s1;
	logic [COL_W-1:0]   col_s1;
	logic               interior_s1;
	logic               border_s1;
	logic               fend_s1;
	logic               three_s1;

	result_t            res_int;
	result_t            res_bdr;
	fifo_push_t         push;

	assign pready = 1'b1;

	demb_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.cfg     (cfg)
	);

	// s1 empties when the queue has room for two results
	assign s1_move  = (level <= FIFO_CW'(FIFO_DEPTH - 2));
	assign in_stall = valid_s1 && !s1_move;
	assign accept   = in_valid && !in_stall;

	assign cur = cfg.three ? {in_data.pixel_c2, in_data.pixel_c1, in_data.pixel_c0}
	                       : {16'd0, in_data.pixel_c0};

	assign col_last = ((EW_W'(col_q) + EW_W'(1)) == cfg.width);
	assign row_last = (({1'b0, row_q} + 17'd1) == {1'b0, cfg.height});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q <= '0;
			col_q <= '0;
		end else if (cfg.restart) begin
			row_q <= '0;
			col_q <= '0;
		end else if (accept) begin
			if (col_last) begin
				col_q <= '0;
				row_q <= row_last ? '0 : row_q + ROW_W'(1);
			end else begin
				col_q <= col_q + COL_W'(1);
			end
		end
	end

	demb_line_buf u_line_buf (
		.clk   (clk),
		.en    (accept),
		.addr  ({row_q[0], col_q}),
		.wdata (cur),
		.old   (old)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (s1_move) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cur_s1      <= cur;
			row_s1      <= row_q;
			col_s1      <= col_q;
			interior_s1 <= (row_q >= ROW_W'(2)) && (col_q >= COL_W'(2));
			border_s1   <= (row_q == '0) || row_last || (col_q == '0) || col_last;
			fend_s1     <= row_last && col_last;
			three_s1    <= cfg.three;
		end
	end

	always_comb begin
		res_int.out_row     = row_s1 - ROW_W'(1);
		res_int.out_col     = OUT_COL_W'(col_s1 - COL_W'(1));
		res_int.out_c0      = emboss(cur_s1[7:0], old[7:0]);
		res_int.out_c1      = three_s1 ? emboss(cur_s1[15:8], old[15:8]) : 8'd0;
		res_int.out_c2      = three_s1 ? emboss(cur_s1[23:16], old[23:16]) : 8'd0;
		res_int.last_of_run = !border_s1;
		res_int.frame_end   = 1'b0;

		res_bdr.out_row     = row_s1;
		res_bdr.out_col     = OUT_COL_W'(col_s1);
		res_bdr.out_c0      = cur_s1[7:0];
		res_bdr.out_c1      = three_s1 ? cur_s1[15:8] : 8'd0;
		res_bdr.out_c2      = three_s1 ? cur_s1[23:16] : 8'd0;
		res_bdr.last_of_run = 1'b1;
		res_bdr.frame_end   = fend_s1;

		push.first  = interior_s1 ? res_int : res_bdr;
		push.second = res_bdr;
		if (valid_s1 && s1_move) begin
			push.count = 2'(interior_s1) + 2'(border_s1);
		end else begin
			push.count = 2'd0;
		end
	end

	demb_fifo u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.pop    (!out_stall),
		.valid  (out_valid),
		.head   (out_data),
		.level  (level)
	);

	a_level_bound: assert property (@(posedge clk) disable iff (!arst_n)
		level <= FIFO_CW'(FIFO_DEPTH))
		else $error("result queue overflow");

	a_accept_fills_s1: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> valid_s1)
		else $error("accepted request not held in s1");

	a_fend_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.frame_end |-> out_data.last_of_run)
		else $error("frame end result not last of run");

	a_interior_pos: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && interior_s1 |-> (row_s1 >= ROW_W'(2)) && (col_s1 >= COL_W'(2)))
		else $error("interior result at invalid position");

endmodule

FILE: tb/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Drives raster pixel frames through the diagonal emboss filter under random
// sender gaps and receiver stalls, reprograms frame size and channel mode over
// the APB port while the filter is idle, and checks every result against a local model
// of the row buffers, position counters and clamped diagonal difference.
// ----------------------------------------------------------------------------
module testbench;
	import demb_pkg::*;

	logic                 clk;
	logic                 arst_n    = 1'b0;
	logic                 in_valid  = 1'b0;
	logic                 in_stall;
	pixel_in_t            in_data   = '0;
	logic                 out_valid;
	logic                 out_stall = 1'b0;
	result_t              out_data;
	logic                 psel      = 1'b0;
	logic                 penable   = 1'b0;
	logic                 pwrite    = 1'b0;
	logic [PADDR_W-1:0]   paddr     = '0;
	logic [PDATA_W-1:0]   pwdata    = '0;
	logic [PDATA_W-1:0]   prdata;
	logic                 pready;

	diagonal_emboss_filter uut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.in_data(in_data),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_data(out_data),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	// filter model state
	logic [CFG_W_W-1:0] cfg_width  = RST_WIDTH;
	logic [ROW_W-1:0]   cfg_height = RST_HEIGHT;
	logic               cfg_three  = 1'b1;
	logic [PIX_W-1:0]   line_mem [0:LB_DEPTH-1];
	int unsigned        pos_row    = 0;
	int unsigned        pos_col    = 0;
	logic [PIX_W-1:0]   tap1       = '0;
	logic [PIX_W-1:0]   tap2       = '0;

	pixel_in_t   pending_pixels [$];
	result_t     expected_results [$];
	int unsigned mismatch_count = 0;
	bit          send_gap_on    = 1'b0;
	bit          recv_stall_on  = 1'b0;
	int unsigned send_gap       = 0;
	int unsigned stall_left     = 0;
	int unsigned stall_draw     = 0;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#10_000_000;
		$display("end of test: mismatches");
		$finish;
	end

	function automatic int unsigned eff_width();
		if (cfg_width == 0)
			return 1;
		if (cfg_width > MAX_WIDTH)
			return MAX_WIDTH;
		return cfg_width;
	endfunction

	function automatic int unsigned eff_height();
		return (cfg_height == 0) ? 1 : cfg_height;
	endfunction

	function automatic logic [7:0] diag_emboss(input logic [7:0] now_px, input logic [7:0] old_px);
		int v;
		v = int'(now_px) - int'(old_px) + int'(EMB_MID);
		if (v < 0)
			v = 0;
		else if (v > int'(EMB_MAX))
			v = int'(EMB_MAX);
		return v[7:0];
	endfunction

	function automatic result_t pack_result(input int unsigned r, input int unsigned c,
			input logic [PIX_W-1:0] pix, input logic fend);
		result_t res;
		res.out_row     = r[15:0];
		res.out_col     = c[OUT_COL_W-1:0];
		res.out_c0      = pix[7:0];
		res.out_c1      = cfg_three ? pix[15:8] : 8'd0;
		res.out_c2      = cfg_three ? pix[23:16] : 8'd0;
		res.last_of_run = 1'b0;
		res.frame_end   = fend;
		return res;
	endfunction

	function automatic void apply_write(input reg_idx_t idx, input logic [PDATA_W-1:0] value);
		case (idx)
			REG_WIDTH: cfg_width = value[CFG_W_W-1:0];
			REG_HEIGHT: cfg_height = value[ROW_W-1:0];
			REG_THREE: cfg_three = value[0];
			default: return;
		endcase
		pos_row = 0;
		pos_col = 0;
	endfunction

	function automatic void filter_pixel(input pixel_in_t px);
		int unsigned w, h, r, c, addr;
		logic [PIX_W-1:0] cur, rd, old, emb;
		result_t inner_res, border_res;
		bit have_inner, have_border;
		w = eff_width();
		h = eff_height();
		r = pos_row;
		c = pos_col;
		if (c >= w)
			c = w - 1;
		if (r >= h)
			r = h - 1;
		cur = {px.pixel_c2, px.pixel_c1, px.pixel_c0};
		if (!cfg_three)
			cur[23:8] = '0;
		addr = (r % 2) * MAX_WIDTH + c;
		rd = line_mem[addr];
		line_mem[addr] = cur;
		old = tap2;
		tap2 = tap1;
		tap1 = rd;
		have_inner = (r >= 2 && c >= 2);
		have_border = (r == 0 || r == h - 1 || c == 0 || c == w - 1);
		emb = {diag_emboss(cur[23:16], old[23:16]), diag_emboss(cur[15:8], old[15:8]),
			diag_emboss(cur[7:0], old[7:0])};
		inner_res = pack_result(r - 1, c - 1, emb, 1'b0);
		border_res = pack_result(r, c, cur, (r == h - 1 && c == w - 1));
		if (have_border)
			border_res.last_of_run = 1'b1;
		else
			inner_res.last_of_run = 1'b1;
		if (have_inner)
			expected_results.push_back(inner_res);
		if (have_border)
			expected_results.push_back(border_res);
		c++;
		if (c >= w) begin
			c = 0;
			r++;
			if (r >= h)
				r = 0;
		end
		pos_row = r;
		pos_col = c;
	endfunction

	task automatic compare_field(input string name, input logic [31:0] want,
			input logic [31:0] got);
		if (got !== want) begin
			$display("%0t: %s expected %0h actual %0h", $time, name, want, got);
			mismatch_count++;
		end
	endtask

	task automatic check_result(input result_t got);
		result_t want;
		if (expected_results.size() == 0) begin
			$display("%0t: result expected none actual %h", $time, got);
			mismatch_count++;
		end else begin
			want = expected_results.pop_front();
			compare_field("out_row", 32'(want.out_row), 32'(got.out_row));
			compare_field("out_col", 32'(want.out_col), 32'(got.out_col));
			compare_field("out_c0", 32'(want.out_c0), 32'(got.out_c0));
			compare_field("out_c1", 32'(want.out_c1), 32'(got.out_c1));
			compare_field("out_c2", 32'(want.out_c2), 32'(got.out_c2));
			compare_field("last_of_run", 32'(want.last_of_run), 32'(got.last_of_run));
			compare_field("frame_end", 32'(want.frame_end), 32'(got.frame_end));
		end
	endtask

	// pixel request driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			in_data <= '0;
			send_gap <= 0;
		end else begin
			if (in_valid && !in_stall) begin
				filter_pixel(in_data);
				void'(pending_pixels.pop_front());
			end
			if (!(in_valid && in_stall)) begin
				if (send_gap != 0) begin
					in_valid <= 1'b0;
					send_gap <= send_gap - 1;
				end else if (pending_pixels.size() != 0) begin
					in_valid <= 1'b1;
					in_data <= pending_pixels[0];
					send_gap <= send_gap_on ? $urandom_range(0, 6) : 0;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// result monitor
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
			stall_left <= 0;
		end else if (out_valid && !out_stall) begin
			check_result(out_data);
			stall_draw = recv_stall_on ? $urandom_range(0, 6) : 0;
			out_stall <= (stall_draw != 0);
			stall_left <= (stall_draw == 0) ? 0 : stall_draw - 1;
		end else if (stall_left != 0) begin
			out_stall <= 1'b1;
			stall_left <= stall_left - 1;
		end else begin
			out_stall <= 1'b0;
		end
	end

	function automatic logic [7:0] rand_channel();
		case ($urandom_range(0, 5))
			0: return 8'd0;
			1: return 8'd255;
			default: return 8'($urandom_range(0, 255));
		endcase
	endfunction

	function automatic pixel_in_t rand_pixel();
		return pixel_in_t'{rand_channel(), rand_channel(), rand_channel()};
	endfunction

	task automatic wait_drained();
		while (pending_pixels.size() != 0 || in_valid || expected_results.size() != 0)
			@(negedge clk);
		repeat (8) @(negedge clk);
	endtask

	task automatic write_reg(input reg_idx_t idx, input logic [PDATA_W-1:0] value);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		apply_write(idx, value);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(negedge clk);
	endtask

	task automatic set_frame(input int unsigned w, input int unsigned h, input bit three);
		write_reg(REG_WIDTH, w);
		write_reg(REG_HEIGHT, h);
		write_reg(REG_THREE, 32'(three));
	endtask

	task automatic send_random(input int unsigned total);
		int unsigned left, chunk;
		left = total;
		while (left != 0) begin
			chunk = $urandom_range(1, 64);
			if (chunk > left)
				chunk = left;
			send_gap_on = ($urandom_range(0, 3) != 0);
			recv_stall_on = ($urandom_range(0, 3) != 0);
			repeat (chunk) pending_pixels.push_back(rand_pixel());
			while (pending_pixels.size() != 0)
				@(negedge clk);
			if ($urandom_range(0, 7) == 0)
				wait_drained();
			left -= chunk;
		end
	endtask

	initial begin
		int unsigned random_sent, w, h, frame_px, n;
		random_sent = 0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		send_gap_on = 1'b1;
		recv_stall_on = 1'b1;
		pending_pixels.push_back(pixel_in_t'{8'd0, 8'd0, 8'd0});
		pending_pixels.push_back(pixel_in_t'{8'd255, 8'd255, 8'd255});
		pending_pixels.push_back(pixel_in_t'{8'h55, 8'hAA, 8'h0F});
		wait_drained();

		// 3x3 frame, center clamps low, high and sits at mid-scale
		set_frame(3, 3, 1'b1);
		pending_pixels.push_back(pixel_in_t'{8'd255, 8'd0, 8'd77});
		repeat (3) pending_pixels.push_back(rand_pixel());
		wait_drained();
		write_reg(REG_NONE, 32'd5);
		repeat (4) pending_pixels.push_back(rand_pixel());
		pending_pixels.push_back(pixel_in_t'{8'd0, 8'd255, 8'd77});
		wait_drained();

		// single channel, upper channels must read zero
		write_reg(REG_THREE, 32'd0);
		pending_pixels.push_back(pixel_in_t'{8'd100, 8'd255, 8'd255});
		repeat (7) pending_pixels.push_back(rand_pixel());
		pending_pixels.push_back(pixel_in_t'{8'd90, 8'd0, 8'd255});
		wait_drained();

		write_reg(REG_WIDTH, 32'd0);
		write_reg(REG_HEIGHT, 32'd0);
		repeat (3) pending_pixels.push_back(rand_pixel());
		wait_drained();

		set_frame(1, 65535, 1'b1);
		send_random(50);
		wait_drained();

		while (random_sent < 420) begin
			case ($urandom_range(0, 9))
				0: w = 0;
				1: w = 1;
				2: w = 2;
				3: w = $urandom_range(MAX_WIDTH + 1, 4095);
				default: w = $urandom_range(3, 12);
			endcase
			case ($urandom_range(0, 9))
				0: h = 0;
				1: h = 1;
				2: h = 2;
				3: h = $urandom_range(60000, 65535);
				default: h = $urandom_range(3, 8);
			endcase
			case ($urandom_range(0, 3))
				0: write_reg(REG_WIDTH, w);
				1: write_reg(REG_HEIGHT, h);
				default: set_frame(w, h, 1'($urandom_range(0, 1)));
			endcase
			if ($urandom_range(0, 5) == 0)
				write_reg(REG_NONE, $urandom);
			frame_px = eff_width() * eff_height();
			n = $urandom_range(1, 2) * frame_px + $urandom_range(0, frame_px);
			if (n > 150)
				n = $urandom_range(40, 150);
			send_random(n);
			wait_drained();
			random_sent += n;
		end

		wait_drained();
		if (mismatch_count == 0 && expected_results.size() == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

endmodule

FILE: sim.f
src/demb_pkg.sv
src/demb_cfg.sv
src/demb_line_buf.sv
src/demb_fifo.sv
src/diagonal_emboss_filter.sv
tb/testbench.sv
